// ===== rtl/core/stream_vbyte_delta_decode_defines.svh =====
// Assertion macros for the group decoder. Simulation builds get the
// concurrent assertions; synthesis builds get empty bodies.
`ifndef STREAM_VBYTE_DELTA_DECODE_DEFINES_SVH
`define STREAM_VBYTE_DELTA_DECODE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define SVDD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svdd same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SVDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svdd next-cycle check failed");

`else

`define SVDD_ASSERT_SAME(label, clk, rst, ante, cons)
`define SVDD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/svdd_pkg.sv =====
`default_nettype none

package svdd_pkg;

   localparam int LANES        = 4;
   localparam int BYTE_W       = 8;
   localparam int WINDOW_BYTES = 16;
   localparam int HALF_W       = 64;
   localparam int WINDOW_W     = WINDOW_BYTES * BYTE_W;
   localparam int VALUE_W      = 32;
   localparam int CODE_W       = 2;
   localparam int KEY_W        = LANES * CODE_W;
   localparam int MAX_LEN      = VALUE_W / BYTE_W;
   localparam int POS_W        = $clog2(WINDOW_BYTES);
   localparam int COUNT_W      = 5;

   localparam logic [BYTE_W-1:0]  BYTE_MASK = 8'hFF;
   localparam logic [COUNT_W-1:0] MIN_BYTES = COUNT_W'(LANES);
   localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(WINDOW_BYTES);

   typedef logic [VALUE_W-1:0] value_type;

   // One decoded group on its way from the lanes to the merge stage.
   typedef struct packed {
      logic [LANES-1:0][VALUE_W-1:0] delta;
      logic                          restart;
      logic [VALUE_W-1:0]            start_value;
      logic [COUNT_W-1:0]            bytes_used;
   } grp_type;

   // One finished result.
   typedef struct packed {
      logic [LANES-1:0][VALUE_W-1:0] sum;
      logic [COUNT_W-1:0]            bytes_used;
   } res_type;

   // Byte length of a value with the given code.
   function automatic logic [COUNT_W-1:0] code_len(input logic [CODE_W-1:0] code);
      return COUNT_W'(code) + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/svdd_req_if.sv =====
`default_nettype none

interface svdd_req_if;
   logic                               valid;
   logic                               ready;
   logic [svdd_pkg::KEY_W-1:0]         key_byte;
   logic [svdd_pkg::HALF_W-1:0]        window_low;
   logic [svdd_pkg::HALF_W-1:0]        window_high;
   logic                               restart;
   logic [svdd_pkg::VALUE_W-1:0]       start_value;

   modport source (
      output valid, key_byte, window_low, window_high, restart, start_value,
      input  ready
   );

   modport sink (
      input  valid, key_byte, window_low, window_high, restart, start_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/svdd_rsp_if.sv =====
`default_nettype none

interface svdd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [svdd_pkg::VALUE_W-1:0]   sum0;
   logic [svdd_pkg::VALUE_W-1:0]   sum1;
   logic [svdd_pkg::VALUE_W-1:0]   sum2;
   logic [svdd_pkg::VALUE_W-1:0]   sum3;
   logic [svdd_pkg::COUNT_W-1:0]   bytes_used;

   modport source (
      output valid, sum0, sum1, sum2, sum3, bytes_used,
      input  ready
   );

   modport sink (
      input  valid, sum0, sum1, sum2, sum3, bytes_used,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/svdd_lane.sv =====
`default_nettype none

// Gathers one little-endian delta of code+1 bytes from the window,
// starting at the given byte offset. Unused upper bytes read as zero.
module svdd_lane (
   input  wire logic [svdd_pkg::WINDOW_W-1:0] window,
   input  wire logic [svdd_pkg::POS_W-1:0]    offset,
   input  wire logic [svdd_pkg::CODE_W-1:0]   code,
   output logic      [svdd_pkg::VALUE_W-1:0]  delta
);

   always_comb begin
      logic [svdd_pkg::POS_W-1:0] pos;
      delta = '0;
      pos   = '0;
      for (int b = 0; b < svdd_pkg::MAX_LEN; b++) begin
         pos = offset + svdd_pkg::POS_W'(b);
         if (svdd_pkg::CODE_W'(b) <= code) begin
            delta[b*svdd_pkg::BYTE_W +: svdd_pkg::BYTE_W] =
               window[pos*svdd_pkg::BYTE_W +: svdd_pkg::BYTE_W] & svdd_pkg::BYTE_MASK;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/svdd_merge.sv =====
`default_nettype none

// Combines the four lane deltas: a local prefix sum in the first stage,
// then the running value is added in the second, which also owns the
// running value register and the output register.
module svdd_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire svdd_pkg::grp_type      in_grp,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output svdd_pkg::res_type           out_res,
   output svdd_pkg::value_type         running_value
);

   typedef struct packed {
      logic [svdd_pkg::LANES-1:0][svdd_pkg::VALUE_W-1:0] prefix;
      logic                                              restart;
      logic [svdd_pkg::VALUE_W-1:0]                      start_value;
      logic [svdd_pkg::COUNT_W-1:0]                      bytes_used;
   } pfx_type;

   logic                  pfx_valid_ff;
   pfx_type               pfx_ff;
   pfx_type               pfx_in;
   logic                  pfx_ready;

   logic                  res_valid_ff;
   svdd_pkg::res_type     res_ff;
   svdd_pkg::res_type     res_in;
   logic                  res_ready;

   svdd_pkg::value_type   run_ff;
   svdd_pkg::value_type   run_in;
   svdd_pkg::value_type   base;
   svdd_pkg::value_type   pair_lo;
   svdd_pkg::value_type   pair_hi;

   assign res_ready = !res_valid_ff || out_ready;
   assign pfx_ready = !pfx_valid_ff || res_ready;
   assign in_ready  = pfx_ready;

   // Prefix tree: two adders deep.
   always_comb begin
      pair_lo               = in_grp.delta[0] + in_grp.delta[1];
      pair_hi               = in_grp.delta[2] + in_grp.delta[3];
      pfx_in.prefix[0]      = in_grp.delta[0];
      pfx_in.prefix[1]      = pair_lo;
      pfx_in.prefix[2]      = pair_lo + in_grp.delta[2];
      pfx_in.prefix[3]      = pair_lo + pair_hi;
      pfx_in.restart        = in_grp.restart;
      pfx_in.start_value    = in_grp.start_value;
      pfx_in.bytes_used     = in_grp.bytes_used;
   end

   // The running value loop holds a single add.
   always_comb begin
      base = pfx_ff.restart ? pfx_ff.start_value : run_ff;
      for (int i = 0; i < svdd_pkg::LANES; i++) begin
         res_in.sum[i] = base + pfx_ff.prefix[i];
      end
      res_in.bytes_used = pfx_ff.bytes_used;
      run_in            = res_in.sum[svdd_pkg::LANES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pfx_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         if (pfx_ready) begin
            pfx_valid_ff <= in_valid;
         end
         if (res_ready) begin
            res_valid_ff <= pfx_valid_ff;
            if (pfx_valid_ff) begin
               run_ff <= run_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pfx_ready && in_valid) begin
         pfx_ff <= pfx_in;
      end
      if (res_ready && pfx_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_res       = res_ff;
   assign running_value = run_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stream_vbyte_delta_decode.sv =====
// Items pass the lane, prefix and output registers; the running value loop
// is a single 32-bit add. One item per cycle while the output does not stall.
// Each stage holds its item only while the next is full, so bubbles close up.
// Reset (synchronous, active high) empties all stages and clears the running value.
`default_nettype none

`include "stream_vbyte_delta_decode_defines.svh"

module stream_vbyte_delta_decode (
   input  wire logic   clock,
   input  wire logic   reset,
   svdd_req_if.sink    req,
   svdd_rsp_if.source  rsp
);

   // The window as one vector, byte 0 in the low bits.
   logic [svdd_pkg::WINDOW_W-1:0]                     window;

   // Byte length of each value and the byte offset where it starts. An
   // offset never exceeds twelve, so it fits the narrow position width.
   logic [svdd_pkg::LANES-1:0][svdd_pkg::COUNT_W-1:0] len;
   logic [svdd_pkg::LANES-1:0][svdd_pkg::COUNT_W-1:0] start_pos;
   logic [svdd_pkg::LANES-1:0][svdd_pkg::POS_W-1:0]   offset;
   logic [svdd_pkg::COUNT_W-1:0]                      total;

   // Lane stage register: one decoded group of four deltas.
   logic                                              lane_valid_ff;
   svdd_pkg::grp_type                                 lane_ff;
   svdd_pkg::grp_type                                 lane_in;
   logic                                              lane_ready;

   logic                                              merge_ready;
   logic                                              merge_valid;
   svdd_pkg::res_type                                 merge_res;
   svdd_pkg::value_type                               running_value;

   assign window = {req.window_high, req.window_low};

   // Offsets are a prefix sum over four two-bit codes; narrow enough to
   // sit in front of the lanes in the same cycle.
   always_comb begin
      for (int i = 0; i < svdd_pkg::LANES; i++) begin
         len[i] = svdd_pkg::code_len(req.key_byte[i*svdd_pkg::CODE_W +: svdd_pkg::CODE_W]);
      end
      start_pos[0] = '0;
      for (int i = 1; i < svdd_pkg::LANES; i++) begin
         start_pos[i] = start_pos[i-1] + len[i-1];
      end
      for (int i = 0; i < svdd_pkg::LANES; i++) begin
         offset[i] = start_pos[i][svdd_pkg::POS_W-1:0];
      end
      total = start_pos[svdd_pkg::LANES-1] + len[svdd_pkg::LANES-1];
   end

   // Four lanes, each pulling one delta out of the window.
   for (genvar g = 0; g < svdd_pkg::LANES; g++) begin : g_lane
      svdd_lane u_lane (
         .window (window),
         .offset (offset[g]),
         .code   (req.key_byte[g*svdd_pkg::CODE_W +: svdd_pkg::CODE_W]),
         .delta  (lane_in.delta[g])
      );
   end

   assign lane_in.restart     = req.restart;
   assign lane_in.start_value = req.start_value;
   assign lane_in.bytes_used  = total;

   // The lane stage takes a new item whenever it is empty or its item
   // moves on to the merge stage in the same cycle.
   assign lane_ready = !lane_valid_ff || merge_ready;
   assign req.ready  = lane_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else if (lane_ready) begin
         lane_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ready && req.valid) begin
         lane_ff <= lane_in;
      end
   end

   // The merge stage forms the prefix sums, adds the running value (or the
   // start value on a restart) and holds the output register.
   svdd_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (lane_valid_ff),
      .in_ready      (merge_ready),
      .in_grp        (lane_ff),
      .out_valid     (merge_valid),
      .out_ready     (rsp.ready),
      .out_res       (merge_res),
      .running_value (running_value)
   );

   assign rsp.valid      = merge_valid;
   assign rsp.sum0       = merge_res.sum[0];
   assign rsp.sum1       = merge_res.sum[1];
   assign rsp.sum2       = merge_res.sum[2];
   assign rsp.sum3       = merge_res.sum[3];
   assign rsp.bytes_used = merge_res.bytes_used;

   // An accepted item always lands in the lane stage.
   `SVDD_ASSERT_NEXT(a_accept_fills_lane, clock, reset, req.valid && req.ready, lane_valid_ff)

   // The running value is loaded together with the output register, so a
   // waiting result always shows the current running value as its last sum.
   `SVDD_ASSERT_SAME(a_running_matches_sum3, clock, reset, rsp.valid, running_value == rsp.sum3)

   // A stalled result must not let the running value move on.
   `SVDD_ASSERT_NEXT(a_stall_holds_running, clock, reset, rsp.valid && !rsp.ready, $stable(running_value))

   // Every group consumes between four and sixteen bytes.
   `SVDD_ASSERT_SAME(a_bytes_in_range, clock, reset, rsp.valid, (rsp.bytes_used >= svdd_pkg::MIN_BYTES) && (rsp.bytes_used <= svdd_pkg::MAX_BYTES))

endmodule

`default_nettype wire
